// File: rtl/core/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types, register codes and constants of the ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

  localparam int ADDR_BITS    = 27;
  localparam int NUM_COEFS    = 16;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFS_0_TO_3   = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFS_4_TO_7   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFS_8_TO_11  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFS_12_TO_15 = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_NIBBLE   = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_NIBBLE    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_PS        = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_HIST      = 4'd7;

  localparam logic [ADDR_BITS-1:0] NIBBLE_RESET = ADDR_BITS'(2);

  // rounding bias and saturation codes of the output stage
  localparam logic signed [39:0] ROUND_BIAS = 40'sd32768;
  localparam logic [15:0]        SAT_POS    = 16'h7fff;
  localparam logic [15:0]        SAT_NEG    = 16'h8000;
  localparam logic [4:0]         SCALE_BASE = 5'd11;  // 2048 = 2^11

  typedef struct packed {
    logic [NUM_COEFS-1:0][15:0] coefs;
    logic [ADDR_BITS-1:0]       start_nibble;
    logic [ADDR_BITS-1:0]       stop_nibble;
    logic [6:0]                 init_ps;
    logic [31:0]                init_hist;
  } cfg_t;

  // one unit of back-end work
  typedef struct packed {
    logic        is_err;
    logic        last;
    logic        load;   // load histories from hist before this sample
    logic [3:0]  nib;
    logic [6:0]  ps;
    logic [31:0] hist;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_chan_t;

endpackage

// File: rtl/core/adpcm_if.sv
// ----------------------------------------------------------------------------
// adpcm_if
// Handshake channels of the ADPCM decoder: bytes in, samples out, config.
// ----------------------------------------------------------------------------
interface adpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, data_byte, first, input ready);
  modport sink   (input valid, data_byte, first, output ready);
endinterface

interface adpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               error;

  modport source (output valid, sample, last, error, input ready);
  modport sink   (input valid, sample, last, error, output ready);
endinterface

interface adpcm_cfg_if;
  import adpcm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/adpcm_front.sv
// ----------------------------------------------------------------------------
// adpcm_front
// Byte intake: tracks the nibble address and frame header, and turns each
// byte into zero, one or two decode operations for the back end.
// ----------------------------------------------------------------------------
module adpcm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adpcm_pkg::cfg_t    cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               first_i,
  output adpcm_pkg::op_chan_t push_o,
  input  logic               q_ready_i
);
  import adpcm_pkg::*;

  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [6:0]           ps_q, ps_d;
  logic                 active_q, active_d;
  logic                 load_pend_q, load_pend_d;
  logic [31:0]          snap_q, snap_d;
  op_t                  pend0_q, pend1_q, op0, op1;
  logic [1:0]           cnt_q, nops;

  logic [ADDR_BITS-1:0] a, a1, a2;
  logic [6:0]           ps;
  logic                 act, lp, pushed, accept;
  logic [31:0]          snap;

  function automatic op_t mk_sample(logic [3:0] nib, logic last, logic load,
                                    logic [6:0] ps_v, logic [31:0] hist);
    op_t o;
    o.is_err = 1'b0;
    o.last   = last;
    o.load   = load;
    o.nib    = nib;
    o.ps     = ps_v;
    o.hist   = hist;
    return o;
  endfunction

  assign push_o.valid = (cnt_q != 2'd0);
  assign push_o.op    = pend0_q;
  assign pushed       = push_o.valid && q_ready_i;
  assign in_ready_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pushed);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    a    = first_i ? cfg_i.start_nibble : addr_q;
    ps   = first_i ? cfg_i.init_ps : ps_q;
    act  = first_i || active_q;
    lp   = first_i || load_pend_q;
    snap = first_i ? cfg_i.init_hist : snap_q;
    a1   = a + ADDR_BITS'(1);
    a2   = a + ADDR_BITS'(2);

    addr_d      = a;
    ps_d        = ps;
    active_d    = act;
    load_pend_d = lp;
    snap_d      = snap;
    nops        = 2'd0;
    op0         = '0;
    op1         = '0;

    if (!act) begin
      active_d = 1'b0;
    end else if (a > cfg_i.stop_nibble) begin
      active_d = 1'b0;
    end else if (a[3:0] == 4'd0) begin
      // frame header
      if (data_byte_i[7]) begin
        op0.is_err = 1'b1;
        nops       = 2'd1;
        active_d   = 1'b0;
      end else begin
        ps_d   = data_byte_i[6:0];
        addr_d = a2;
        if (a2 > cfg_i.stop_nibble) active_d = 1'b0;
      end
    end else if (a[0]) begin
      // odd address: low nibble only
      op0         = mk_sample(data_byte_i[3:0], a == cfg_i.stop_nibble, lp, ps, snap);
      nops        = 2'd1;
      load_pend_d = 1'b0;
      addr_d      = a1;
      if ((a == cfg_i.stop_nibble) || (a1 > cfg_i.stop_nibble)) active_d = 1'b0;
    end else begin
      op0         = mk_sample(data_byte_i[7:4], a == cfg_i.stop_nibble, lp, ps, snap);
      nops        = 2'd1;
      load_pend_d = 1'b0;
      addr_d      = a1;
      if ((a == cfg_i.stop_nibble) || (a1 > cfg_i.stop_nibble)) begin
        active_d = 1'b0;
      end else begin
        op1    = mk_sample(data_byte_i[3:0], a1 == cfg_i.stop_nibble, 1'b0, ps, snap);
        nops   = 2'd2;
        addr_d = a2;
        if ((a1 == cfg_i.stop_nibble) || (a2 > cfg_i.stop_nibble)) active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      ps_q        <= '0;
      active_q    <= 1'b0;
      load_pend_q <= 1'b0;
      snap_q      <= '0;
      cnt_q       <= 2'd0;
    end else begin
      if (accept) begin
        addr_q      <= addr_d;
        ps_q        <= ps_d;
        active_q    <= active_d;
        load_pend_q <= load_pend_d;
        snap_q      <= snap_d;
        cnt_q       <= nops;
      end else if (pushed) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend0_q <= op0;
      pend1_q <= op1;
    end else if (pushed) begin
      pend0_q <= pend1_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3) && (!accept || (cnt_q == 2'd0) || pushed))
    else $error("front: pending ops overrun");

endmodule

// File: rtl/core/adpcm_queue.sv
// ----------------------------------------------------------------------------
// adpcm_queue
// Short op queue between front and back end.
// ----------------------------------------------------------------------------
module adpcm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adpcm_pkg::op_chan_t push_i,
  output logic                push_ready_o,
  output adpcm_pkg::op_chan_t head_o,
  input  logic                pop_i
);
  import adpcm_pkg::*;

  op_t                 mem_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_BITS:0]   count_q;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != (Q_PTR_BITS+1)'(Q_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(1);
      if (do_push && !do_pop)      count_q <= count_q + (Q_PTR_BITS+1)'(1);
      else if (do_pop && !do_push) count_q <= count_q - (Q_PTR_BITS+1)'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= (Q_PTR_BITS+1)'(Q_DEPTH)) &&
    ((count_q - (Q_PTR_BITS+1)'(wr_ptr_q - rd_ptr_q)) % (Q_DEPTH) == 0))
    else $error("queue: count and pointers disagree");

endmodule

// File: rtl/core/adpcm_back.sv
// ----------------------------------------------------------------------------
// adpcm_back
// Sample arithmetic: predictor multiply stage, accumulate/round/saturate
// stage, sample histories and the result register.
// ----------------------------------------------------------------------------
module adpcm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adpcm_pkg::cfg_t     cfg_i,
  input  adpcm_pkg::op_chan_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  sample_o,
  output logic                last_o,
  output logic                error_o
);
  import adpcm_pkg::*;

  logic signed [15:0] h1_q, h2_q, h1e, h2e, c1, c2;
  logic signed [31:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [3:0]  nib_s;
  logic signed [30:0] nib_w, t_d, t_q;
  logic [4:0]         shamt;
  logic [2:0]         pred;
  logic               s1_vld_q, s1_err_q, s1_last_q;
  logic signed [33:0] acc;
  logic signed [39:0] acc_w, r;
  logic [15:0]        smp;
  logic               drain;
  logic               out_vld_q, out_last_q, out_err_q;
  logic [15:0]        out_smp_q;

  assign pop_o = head_i.valid && !s1_vld_q;
  assign drain = s1_vld_q && (!out_vld_q || out_ready_i);

  // stage 1: predictor products and scaled nibble
  always_comb begin
    h1e   = head_i.op.load ? head_i.op.hist[31:16] : h1_q;
    h2e   = head_i.op.load ? head_i.op.hist[15:0]  : h2_q;
    pred  = head_i.op.ps[6:4];
    c1    = cfg_i.coefs[{pred, 1'b0}];
    c2    = cfg_i.coefs[{pred, 1'b1}];
    p1_d  = c1 * h1e;
    p2_d  = c2 * h2e;
    nib_s = head_i.op.nib;
    nib_w = 31'(nib_s);
    shamt = {1'b0, head_i.op.ps[3:0]} + SCALE_BASE;
    t_d   = nib_w <<< shamt;
  end

  // stage 2: sum, x32 with rounding bias, saturate to 32 bits, keep high half
  always_comb begin
    acc   = 34'(p1_q) + 34'(p2_q) + 34'(t_q);
    acc_w = 40'(acc);
    r     = (acc_w <<< 5) + ROUND_BIAS;
    if (r[39:31] == {9{r[39]}}) smp = r[31:16];
    else if (r[39])             smp = SAT_NEG;
    else                        smp = SAT_POS;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      t_q       <= t_d;
      s1_err_q  <= head_i.op.is_err;
      s1_last_q <= head_i.op.last;
    end
    if (drain) begin
      out_smp_q  <= s1_err_q ? 16'h0000 : smp;
      out_last_q <= s1_last_q && !s1_err_q;
      out_err_q  <= s1_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      h1_q      <= '0;
      h2_q      <= '0;
    end else begin
      if (pop_o)      s1_vld_q <= 1'b1;
      else if (drain) s1_vld_q <= 1'b0;

      if (drain)            out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;

      if (pop_o && head_i.op.load && !head_i.op.is_err) begin
        h1_q <= head_i.op.hist[31:16];
        h2_q <= head_i.op.hist[15:0];
      end else if (drain && !s1_err_q) begin
        h2_q <= h1_q;
        h1_q <= smp;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = out_smp_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain && !s1_err_q) |=> (h1_q == out_smp_q) && !out_err_q)
    else $error("back: history does not follow delivered sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_err_q) |-> (out_smp_q == 16'h0000) && !out_last_q)
    else $error("back: error result carries sample or last");

endmodule

// File: rtl/core/dsp_adpcm_decoder.sv
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder
// Streaming 4-bit DSP ADPCM decoder: payload bytes in, 16-bit PCM out.
// ----------------------------------------------------------------------------
// Usage: program the coefficient, address, predictor/scale and history
// registers, then send payload bytes in address order with first=1 on the
// byte holding start_nibble. Each byte yields zero, one or two samples; the
// sample at the stop address carries last, and a header with bit 7 set yields
// one transaction with error=1 and ends the run. The history recurrence runs
// through a multiply stage and an accumulate/saturate stage, and the back
// end takes no new sample until the last one has passed both. A four-entry
// op queue parts byte intake from the arithmetic and a result register
// parts it from the output, so bytes keep flowing while a sample waits. The
// config port is always ready; write it only between runs or while no
// transaction is pending.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder (
  input logic         clk_i,
  input logic         rst_ni,
  adpcm_in_if.sink    byte_i,
  adpcm_cfg_if.sink   cfg_i,
  adpcm_out_if.source sample_o
);
  import adpcm_pkg::*;

  cfg_t     cfg_q;
  op_chan_t push, head;
  logic     push_ready, pop;

  // configuration registers, write-only, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coefs        <= '0;
      cfg_q.start_nibble <= NIBBLE_RESET;
      cfg_q.stop_nibble  <= NIBBLE_RESET;
      cfg_q.init_ps      <= '0;
      cfg_q.init_hist    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COEFS_0_TO_3:   cfg_q.coefs[3:0]   <= cfg_i.data;
        CFG_COEFS_4_TO_7:   cfg_q.coefs[7:4]   <= cfg_i.data;
        CFG_COEFS_8_TO_11:  cfg_q.coefs[11:8]  <= cfg_i.data;
        CFG_COEFS_12_TO_15: cfg_q.coefs[15:12] <= cfg_i.data;
        CFG_START_NIBBLE:   cfg_q.start_nibble <= cfg_i.data[ADDR_BITS-1:0];
        CFG_STOP_NIBBLE:    cfg_q.stop_nibble  <= cfg_i.data[ADDR_BITS-1:0];
        CFG_INIT_PS:        cfg_q.init_ps      <= cfg_i.data[6:0];
        CFG_INIT_HIST:      cfg_q.init_hist    <= cfg_i.data[31:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // front: address/header tracking, byte -> ops
  adpcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (byte_i.ready),
    .data_byte_i (byte_i.data_byte),
    .first_i     (byte_i.first),
    .push_o      (push),
    .q_ready_i   (push_ready)
  );

  adpcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: two-stage sample arithmetic and result register
  adpcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (sample_o.valid),
    .out_ready_i (sample_o.ready),
    .sample_o    (sample_o.sample),
    .last_o      (sample_o.last),
    .error_o     (sample_o.error)
  );

endmodule
